// ===== sv/assert_macros.svh =====
// Assertion macros shared by the RTL. Each use takes a label, the clock,
// the active-low reset and the property terms, and reports through $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define BKVFT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define BKVFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define BKVFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define BKVFT_ASSERT(label, clk, rst_n, prop, msg)
`define BKVFT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define BKVFT_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== sv/bkvft_pkg.sv =====
package bkvft_pkg;

    // Field widths
    localparam int OP_W    = 3;
    localparam int KEY_W   = 16;
    localparam int VAL_W   = 32;
    localparam int MONEY_W = 64;
    localparam int OUT_W   = 63;
    localparam int STAT_W  = 2;

    // Default table depth
    localparam int FIELD_ENTRIES_DEFAULT = 64;

    // Operation codes
    localparam logic [OP_W-1:0] OP_SET          = 3'd0;
    localparam logic [OP_W-1:0] OP_SIGNED_ADD   = 3'd1;
    localparam logic [OP_W-1:0] OP_UNSIGNED_ADD = 3'd2;
    localparam logic [OP_W-1:0] OP_MONEY_SET    = 3'd3;
    localparam logic [OP_W-1:0] OP_MONEY_ADD    = 3'd4;

    // Status codes
    localparam logic [STAT_W-1:0] STATUS_DONE   = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_REJECT = 2'd2;

    // Keys holding the two halves of the money value
    localparam logic [KEY_W-1:0] MONEY_LOW_KEY  = 16'd3;
    localparam logic [KEY_W-1:0] MONEY_HIGH_KEY = 16'd4;

    // One table entry
    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] val;
    } entry_t;

    // Shared adder request and response
    typedef struct packed {
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] b;
        logic             cin;
    } alu_req_t;

    typedef struct packed {
        logic [VAL_W-1:0] sum;
        logic             cout;
    } alu_rsp_t;

endpackage

// ===== sv/bounded_key_value_field_table_unit.sv =====
// Channel   Handshake              Payload
// input     in_valid / in_ready    operation, key, operand
// output    out_valid / out_ready  status, value_after
//
// For N stored entries the key scan reads each stored slot in turn; then a calc step,
// a step for the high half of a money add, a write and a next step per key written
// and a delete step per key deleted, before the done step loads the output register.
// in_ready is high only while idle; a result waiting in the output register holds the
// sequencer in its done step only. Reset clears the entry count, not the entry memory.
`include "assert_macros.svh"

module bounded_key_value_field_table_unit #(
    parameter int FIELD_ENTRIES = bkvft_pkg::FIELD_ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bkvft_pkg::OP_W-1:0]    operation,
    input  logic [bkvft_pkg::KEY_W-1:0]   key,
    input  logic [bkvft_pkg::MONEY_W-1:0] operand,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bkvft_pkg::STAT_W-1:0]  status,
    output logic [bkvft_pkg::OUT_W-1:0]   value_after
);

    localparam int IDX_W = (FIELD_ENTRIES > 1) ? $clog2(FIELD_ENTRIES) : 1;
    localparam int CNT_W = $clog2(FIELD_ENTRIES + 1);
    localparam int VAL_W = bkvft_pkg::VAL_W;
    localparam int KEY_W = bkvft_pkg::KEY_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_SCAN   = 3'd1;
    localparam logic [2:0] ST_CALC   = 3'd2;
    localparam logic [2:0] ST_ADD_HI = 3'd3;
    localparam logic [2:0] ST_WRITE  = 3'd4;
    localparam logic [2:0] ST_DEL    = 3'd5;
    localparam logic [2:0] ST_NEXT   = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    // Control registers
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] scan_idx_reg, scan_idx_next;
    logic             rd_pend_reg, rd_pend_next;
    logic             found_a_reg, found_a_next;
    logic             found_b_reg, found_b_next;
    logic             full_reg, full_next;
    logic             rej_reg, rej_next;
    logic             phase_b_reg, phase_b_next;
    logic             del_reg, del_next;
    logic             out_valid_reg, out_valid_next;

    // Payload registers
    logic [bkvft_pkg::OP_W-1:0]    op_reg, op_next;
    logic [KEY_W-1:0]              key_a_reg, key_a_next;
    logic [bkvft_pkg::MONEY_W-1:0] opnd_reg, opnd_next;
    logic [IDX_W-1:0]              rd_slot_reg, rd_slot_next;
    logic [IDX_W-1:0]              slot_a_reg, slot_a_next;
    logic [IDX_W-1:0]              slot_b_reg, slot_b_next;
    logic [VAL_W-1:0]              val_a_reg, val_a_next;
    logic [VAL_W-1:0]              val_b_reg, val_b_next;
    logic                          carry_reg, carry_next;
    logic [VAL_W-1:0]              mon_lo_reg, mon_lo_next;
    logic [VAL_W-1:0]              mon_hi_reg, mon_hi_next;
    logic [bkvft_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [bkvft_pkg::OUT_W-1:0]   value_reg, value_next;

    // Memory and adder hookup
    logic [IDX_W-1:0]    rd_addr;
    bkvft_pkg::entry_t   rd_entry;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    bkvft_pkg::entry_t   wr_entry;
    bkvft_pkg::alu_req_t alu_req;
    bkvft_pkg::alu_rsp_t alu_rsp;

    logic [CNT_W-1:0] cnt_dec;
    logic [IDX_W-1:0] last_idx;
    logic [KEY_W-1:0] w_key;
    logic [VAL_W-1:0] w_val;
    logic             w_found;
    logic [IDX_W-1:0] w_slot;
    logic             is_money;

    bkvft_store #(
        .DEPTH (FIELD_ENTRIES),
        .IDX_W (IDX_W)
    ) u_store (
        .clk      (clk),
        .rd_addr  (rd_addr),
        .rd_entry (rd_entry),
        .wr_en    (wr_en),
        .wr_addr  (wr_addr),
        .wr_entry (wr_entry)
    );

    bkvft_alu u_alu (
        .req (alu_req),
        .rsp (alu_rsp)
    );

    // Derived write target for the current phase
    assign cnt_dec  = cnt_reg - CNT_W'(1);
    assign last_idx = cnt_dec[IDX_W-1:0];
    assign w_key    = phase_b_reg ? bkvft_pkg::MONEY_HIGH_KEY : key_a_reg;
    assign w_val    = phase_b_reg ? mon_hi_reg : mon_lo_reg;
    assign w_found  = phase_b_reg ? found_b_reg : found_a_reg;
    assign w_slot   = phase_b_reg ? slot_b_reg : slot_a_reg;
    assign is_money = (op_reg == bkvft_pkg::OP_MONEY_SET) ||
                      (op_reg == bkvft_pkg::OP_MONEY_ADD);

    assign in_ready    = (state_reg == ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign value_after = value_reg;

    // Read address: scan slot, otherwise the last entry for a delete
    assign rd_addr = (state_reg == ST_SCAN) ? scan_idx_reg[IDX_W-1:0] : last_idx;

    // Drive the shared adder
    always_comb
    begin
        alu_req.a   = val_a_reg;
        alu_req.b   = opnd_reg[VAL_W-1:0];
        alu_req.cin = 1'b0;
        if (state_reg == ST_ADD_HI)
        begin
            alu_req.a   = val_b_reg;
            alu_req.b   = opnd_reg[2*VAL_W-1:VAL_W];
            alu_req.cin = carry_reg;
        end
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        scan_idx_next  = scan_idx_reg;
        rd_pend_next   = rd_pend_reg;
        found_a_next   = found_a_reg;
        found_b_next   = found_b_reg;
        full_next      = full_reg;
        rej_next       = rej_reg;
        phase_b_next   = phase_b_reg;
        del_next       = del_reg;
        out_valid_next = out_valid_reg;
        op_next        = op_reg;
        key_a_next     = key_a_reg;
        opnd_next      = opnd_reg;
        rd_slot_next   = rd_slot_reg;
        slot_a_next    = slot_a_reg;
        slot_b_next    = slot_b_reg;
        val_a_next     = val_a_reg;
        val_b_next     = val_b_reg;
        carry_next     = carry_reg;
        mon_lo_next    = mon_lo_reg;
        mon_hi_next    = mon_hi_reg;
        status_next    = status_reg;
        value_next     = value_reg;
        wr_en          = 1'b0;
        wr_addr        = w_slot;
        wr_entry.key   = w_key;
        wr_entry.val   = w_val;

        // Drop the output once it has been taken
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_next       = operation;
                    opnd_next     = operand;
                    key_a_next    = (operation <= bkvft_pkg::OP_UNSIGNED_ADD) ?
                                    key : bkvft_pkg::MONEY_LOW_KEY;
                    scan_idx_next = '0;
                    rd_pend_next  = 1'b0;
                    found_a_next  = 1'b0;
                    found_b_next  = 1'b0;
                    val_a_next    = '0;
                    val_b_next    = '0;
                    full_next     = 1'b0;
                    rej_next      = 1'b0;
                    phase_b_next  = 1'b0;
                    del_next      = 1'b0;
                    mon_lo_next   = '0;
                    mon_hi_next   = '0;
                    if (operation > bkvft_pkg::OP_MONEY_ADD)
                    begin
                        state_next = ST_DONE;
                    end
                    else if (operation == bkvft_pkg::OP_MONEY_SET &&
                             operand[bkvft_pkg::MONEY_W-1])
                    begin
                        rej_next   = 1'b1;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                // Issue one slot per cycle, compare the one read last cycle
                if (scan_idx_reg < cnt_reg)
                begin
                    rd_pend_next  = 1'b1;
                    rd_slot_next  = scan_idx_reg[IDX_W-1:0];
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                else
                begin
                    rd_pend_next = 1'b0;
                    if (!rd_pend_reg)
                    begin
                        state_next = ST_CALC;
                    end
                end
                if (rd_pend_reg)
                begin
                    if (!found_a_reg && rd_entry.key == key_a_reg)
                    begin
                        found_a_next = 1'b1;
                        slot_a_next  = rd_slot_reg;
                        val_a_next   = rd_entry.val;
                    end
                    if (!found_b_reg && rd_entry.key == bkvft_pkg::MONEY_HIGH_KEY)
                    begin
                        found_b_next = 1'b1;
                        slot_b_next  = rd_slot_reg;
                        val_b_next   = rd_entry.val;
                    end
                end
            end
            ST_CALC:
            begin
                state_next = ST_WRITE;
                case (op_reg) inside
                    bkvft_pkg::OP_SET:
                    begin
                        mon_lo_next = opnd_reg[VAL_W-1:0];
                    end
                    bkvft_pkg::OP_SIGNED_ADD, bkvft_pkg::OP_UNSIGNED_ADD:
                    begin
                        mon_lo_next = alu_rsp.sum;
                    end
                    bkvft_pkg::OP_MONEY_SET:
                    begin
                        mon_lo_next = opnd_reg[VAL_W-1:0];
                        mon_hi_next = opnd_reg[2*VAL_W-1:VAL_W];
                    end
                    bkvft_pkg::OP_MONEY_ADD:
                    begin
                        mon_lo_next = alu_rsp.sum;
                        carry_next  = alu_rsp.cout;
                        state_next  = ST_ADD_HI;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end
            ST_ADD_HI:
            begin
                // Clamp a negative sum to zero
                if (alu_rsp.sum[VAL_W-1])
                begin
                    mon_lo_next = '0;
                    mon_hi_next = '0;
                end
                else
                begin
                    mon_hi_next = alu_rsp.sum;
                end
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                del_next   = 1'b0;
                state_next = ST_NEXT;
                if (w_val == '0)
                begin
                    // Delete: fetch the last entry to move into the freed slot
                    if (w_found)
                    begin
                        state_next = ST_DEL;
                    end
                end
                else if (w_found)
                begin
                    wr_en = 1'b1;
                end
                else if (cnt_reg == CNT_W'(FIELD_ENTRIES))
                begin
                    full_next = 1'b1;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_addr  = cnt_reg[IDX_W-1:0];
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            ST_DEL:
            begin
                wr_en      = 1'b1;
                wr_entry   = rd_entry;
                cnt_next   = cnt_dec;
                del_next   = 1'b1;
                state_next = ST_NEXT;
            end
            ST_NEXT:
            begin
                if (is_money && !phase_b_reg)
                begin
                    // Follow the high key if the delete moved it
                    phase_b_next = 1'b1;
                    if (del_reg && slot_b_reg == cnt_reg[IDX_W-1:0])
                    begin
                        slot_b_next = slot_a_reg;
                    end
                    state_next = ST_WRITE;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (rej_reg)
                    begin
                        status_next = bkvft_pkg::STATUS_REJECT;
                        value_next  = '0;
                    end
                    else
                    begin
                        status_next = full_reg ? bkvft_pkg::STATUS_FULL
                                               : bkvft_pkg::STATUS_DONE;
                        if (is_money)
                        begin
                            value_next = {mon_hi_reg[VAL_W-2:0], mon_lo_reg};
                        end
                        else if (full_reg)
                        begin
                            value_next = '0;
                        end
                        else
                        begin
                            value_next = {{(bkvft_pkg::OUT_W-VAL_W){1'b0}}, mon_lo_reg};
                        end
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            scan_idx_reg  <= '0;
            rd_pend_reg   <= 1'b0;
            found_a_reg   <= 1'b0;
            found_b_reg   <= 1'b0;
            full_reg      <= 1'b0;
            rej_reg       <= 1'b0;
            phase_b_reg   <= 1'b0;
            del_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            scan_idx_reg  <= scan_idx_next;
            rd_pend_reg   <= rd_pend_next;
            found_a_reg   <= found_a_next;
            found_b_reg   <= found_b_next;
            full_reg      <= full_next;
            rej_reg       <= rej_next;
            phase_b_reg   <= phase_b_next;
            del_reg       <= del_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        op_reg      <= op_next;
        key_a_reg   <= key_a_next;
        opnd_reg    <= opnd_next;
        rd_slot_reg <= rd_slot_next;
        slot_a_reg  <= slot_a_next;
        slot_b_reg  <= slot_b_next;
        val_a_reg   <= val_a_next;
        val_b_reg   <= val_b_next;
        carry_reg   <= carry_next;
        mon_lo_reg  <= mon_lo_next;
        mon_hi_reg  <= mon_hi_next;
        status_reg  <= status_next;
        value_reg   <= value_next;
    end

    // Checks
    `BKVFT_ASSERT(a_cnt_bound, clk, rst_n, cnt_reg <= CNT_W'(FIELD_ENTRIES), "count over depth")
    `BKVFT_ASSERT_NXT(a_cnt_hold, clk, rst_n, (state_reg != ST_WRITE) && (state_reg != ST_DEL), cnt_reg == $past(cnt_reg), "count moved")
    `BKVFT_ASSERT_IMP(a_full_real, clk, rst_n, (state_reg == ST_DONE) && full_reg && !is_money, cnt_reg == CNT_W'(FIELD_ENTRIES), "false full")
    `BKVFT_ASSERT_IMP(a_scan_slot, clk, rst_n, (state_reg == ST_SCAN) && rd_pend_reg, CNT_W'(rd_slot_reg) < cnt_reg, "scan overrun")

endmodule

// ===== sv/bkvft_alu.sv =====
module bkvft_alu (
    input  bkvft_pkg::alu_req_t req,
    output bkvft_pkg::alu_rsp_t rsp
);

    // 32-bit add with carry in and carry out
    assign {rsp.cout, rsp.sum} = {1'b0, req.a} + {1'b0, req.b}
                               + (bkvft_pkg::VAL_W + 1)'(req.cin);

endmodule

// ===== sv/bkvft_store.sv =====
module bkvft_store #(
    parameter int DEPTH = bkvft_pkg::FIELD_ENTRIES_DEFAULT,
    parameter int IDX_W = $clog2(DEPTH)
) (
    input  logic                clk,
    input  logic [IDX_W-1:0]    rd_addr,
    output bkvft_pkg::entry_t   rd_entry,
    input  logic                wr_en,
    input  logic [IDX_W-1:0]    wr_addr,
    input  bkvft_pkg::entry_t   wr_entry
);

    bkvft_pkg::entry_t mem [DEPTH];

    // Registered read, one address per cycle
    always_ff @(posedge clk)
    begin
        rd_entry <= mem[rd_addr];
    end

    // Single write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_entry;
        end
    end

endmodule

// ===== tb/field_table_checker.sv =====
module field_table_checker #(
    parameter int FIELD_ENTRIES = bkvft_pkg::FIELD_ENTRIES_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic [bkvft_pkg::OP_W-1:0]    operation,
    input  logic [bkvft_pkg::KEY_W-1:0]   key,
    input  logic [bkvft_pkg::MONEY_W-1:0] operand,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bkvft_pkg::STAT_W-1:0]  status,
    input  logic [bkvft_pkg::OUT_W-1:0]   value_after,
    output int                            fail_count,
    output int                            outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W    = bkvft_pkg::OP_W;
    localparam int KEY_W   = bkvft_pkg::KEY_W;
    localparam int VAL_W   = bkvft_pkg::VAL_W;
    localparam int MONEY_W = bkvft_pkg::MONEY_W;
    localparam int OUT_W   = bkvft_pkg::OUT_W;
    localparam int STAT_W  = bkvft_pkg::STAT_W;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [OUT_W-1:0]  value_after;
    } table_reply_t;

    // Replies owed by the block, oldest first
    table_reply_t reply_queue[$];

    // Shadow copy of the table
    int unsigned      live_entries = 0;
    logic [KEY_W-1:0] stored_keys [FIELD_ENTRIES];
    logic [VAL_W-1:0] stored_vals [FIELD_ENTRIES];

    int errors = 0;

    // Linear search from slot zero; -1 when the key is absent
    function automatic int slot_of_key(input logic [KEY_W-1:0] k);
        for (int i = 0; i < int'(live_entries); i++) begin
            if (stored_keys[i] == k)
                return i;
        end
        return -1;
    endfunction

    function automatic logic [VAL_W-1:0] field_of(input logic [KEY_W-1:0] k);
        int s;
        s = slot_of_key(k);
        return (s < 0) ? '0 : stored_vals[s];
    endfunction

    // Write one field; zero deletes by moving the last entry into the hole.
    // Returns zero when a new key finds the table full.
    function automatic bit put_field(input logic [KEY_W-1:0] k,
                                     input logic [VAL_W-1:0] v);
        int          s;
        int unsigned last;
        s = slot_of_key(k);
        if (v == '0) begin
            if (s >= 0) begin
                last           = live_entries - 1;
                stored_keys[s] = stored_keys[last];
                stored_vals[s] = stored_vals[last];
                live_entries   = last;
            end
            return 1'b1;
        end
        if (s >= 0) begin
            stored_vals[s] = v;
            return 1'b1;
        end
        if (live_entries >= FIELD_ENTRIES)
            return 1'b0;
        stored_keys[live_entries] = k;
        stored_vals[live_entries] = v;
        live_entries++;
        return 1'b1;
    endfunction

    // Apply one command to the shadow table and form the reply it owes
    function automatic table_reply_t apply_command(input logic [OP_W-1:0]    op,
                                                   input logic [KEY_W-1:0]   k,
                                                   input logic [MONEY_W-1:0] opnd);
        table_reply_t     r;
        logic [VAL_W-1:0] nv;
        logic [MONEY_W-1:0] money;
        bit               ok_lo;
        bit               ok_hi;
        r.status      = bkvft_pkg::STATUS_DONE;
        r.value_after = '0;
        case (op)
            bkvft_pkg::OP_SET, bkvft_pkg::OP_SIGNED_ADD, bkvft_pkg::OP_UNSIGNED_ADD: begin
                nv = opnd[VAL_W-1:0];
                if (op != bkvft_pkg::OP_SET)
                    nv = field_of(k) + opnd[VAL_W-1:0];
                r.status      = put_field(k, nv) ? bkvft_pkg::STATUS_DONE
                                                 : bkvft_pkg::STATUS_FULL;
                r.value_after = OUT_W'(field_of(k));
            end
            bkvft_pkg::OP_MONEY_SET, bkvft_pkg::OP_MONEY_ADD: begin
                if (op == bkvft_pkg::OP_MONEY_SET && opnd[MONEY_W-1]) begin
                    r.status = bkvft_pkg::STATUS_REJECT;
                end else begin
                    if (op == bkvft_pkg::OP_MONEY_SET) begin
                        money = opnd;
                    end else begin
                        money = {field_of(bkvft_pkg::MONEY_HIGH_KEY),
                                 field_of(bkvft_pkg::MONEY_LOW_KEY)} + opnd;
                        // clamp a negative balance to zero
                        if (money[MONEY_W-1])
                            money = '0;
                    end
                    ok_lo         = put_field(bkvft_pkg::MONEY_LOW_KEY, money[VAL_W-1:0]);
                    ok_hi         = put_field(bkvft_pkg::MONEY_HIGH_KEY,
                                              money[MONEY_W-1:VAL_W]);
                    r.status      = (ok_lo && ok_hi) ? bkvft_pkg::STATUS_DONE
                                                     : bkvft_pkg::STATUS_FULL;
                    r.value_after = money[OUT_W-1:0];
                end
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    // Predict on each input transfer, compare on each output transfer
    always @(posedge clk) begin : watch
        table_reply_t want;
        if (!rst_n) begin
            live_entries = 0;
            reply_queue.delete();
        end else begin
            if (in_valid && in_ready)
                reply_queue.insert(reply_queue.size(),
                                   apply_command(operation, key, operand));
            if (out_valid && out_ready) begin
                if (reply_queue.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected reply, expected none, actual status %0d %s 0x%0h",
                             $time, status, "value_after", value_after);
                end else begin
                    want = reply_queue.pop_front();
                    if (status !== want.status) begin
                        errors++;
                        $display("%0t: status mismatch, expected %0d, actual %0d",
                                 $time, want.status, status);
                    end
                    if (value_after !== want.value_after) begin
                        errors++;
                        $display("%0t: value_after mismatch, expected 0x%0h, actual 0x%0h",
                                 $time, want.value_after, value_after);
                    end
                end
            end
        end
        fail_count  <= errors;
        outstanding <= reply_queue.size();
    end

endmodule

// ===== tb/bounded_key_value_field_table_unit_tb.sv =====
module bounded_key_value_field_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int OP_W    = bkvft_pkg::OP_W;
    localparam int KEY_W   = bkvft_pkg::KEY_W;
    localparam int MONEY_W = bkvft_pkg::MONEY_W;
    localparam int OUT_W   = bkvft_pkg::OUT_W;
    localparam int STAT_W  = bkvft_pkg::STAT_W;

    localparam logic [OP_W-1:0] OP_RESERVED_LO = bkvft_pkg::OP_MONEY_ADD + 3'd1;
    localparam logic [OP_W-1:0] OP_RESERVED_HI = '1;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 200;
    localparam int HOLD_CYCLES  = 400;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic [OP_W-1:0]    operation = bkvft_pkg::OP_SET;
    logic [KEY_W-1:0]   key       = '0;
    logic [MONEY_W-1:0] operand   = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [STAT_W-1:0]  status;
    logic [OUT_W-1:0]   value_after;

    int fail_count;
    int outstanding;

    // Shared control between sender and receiver
    bit calm        = 1'b0;
    bit rx_hold_req = 1'b0;

    bounded_key_value_field_table_unit #(
        .FIELD_ENTRIES(bkvft_pkg::FIELD_ENTRIES_DEFAULT)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key        (key),
        .operand    (operand),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value_after(value_after)
    );

    field_table_checker #(
        .FIELD_ENTRIES(bkvft_pkg::FIELD_ENTRIES_DEFAULT)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .operation  (operation),
        .key        (key),
        .operand    (operand),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .status     (status),
        .value_after(value_after),
        .fail_count (fail_count),
        .outstanding(outstanding)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic logic [MONEY_W-1:0] rand_word64();
        logic [31:0] hi;
        logic [31:0] lo;
        hi = $urandom;
        lo = $urandom;
        return {hi, lo};
    endfunction

    // Field operand: zero low half, small signed delta, or anything
    function automatic logic [MONEY_W-1:0] field_operand(input int zero_pct);
        int                 r;
        logic [MONEY_W-1:0] v;
        r = $urandom_range(0, 99);
        v = rand_word64();
        if (r < zero_pct)
            return {v[63:32], 32'h0};
        if (r < zero_pct + 25)
            return {{56{v[7]}}, v[7:0]};
        return v;
    endfunction

    // Money operand: anything, small, low half zero, negative, large
    function automatic logic [MONEY_W-1:0] money_operand();
        int                 r;
        logic [MONEY_W-1:0] v;
        r = $urandom_range(0, 99);
        v = rand_word64();
        if (r < 15)
            return v;
        if (r < 35)
            return 64'(v[15:0]);
        if (r < 50)
            return {1'b0, v[62:32], 32'h0};
        if (r < 65)
            return -64'(v[15:0]);
        if (r < 85)
            return {1'b0, v[62:0]};
        return -{2'b0, v[61:0]};
    endfunction

    function automatic logic [KEY_W-1:0] pick_key(input logic [KEY_W-1:0] base,
                                                  input int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return r[0] ? bkvft_pkg::MONEY_LOW_KEY : bkvft_pkg::MONEY_HIGH_KEY;
        if (r < 20)
            return KEY_W'($urandom);
        return base + KEY_W'($urandom_range(0, span - 1));
    endfunction

    // Offer one command, with an optional idle gap first; return once transferred
    task automatic send_command(input logic [OP_W-1:0]    op,
                                input logic [KEY_W-1:0]   k,
                                input logic [MONEY_W-1:0] opnd);
        int gap;
        if (!calm && $urandom_range(0, 99) < 33) begin
            gap      = $urandom_range(1, 8);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        operand   <= opnd;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    // Drop valid and wait until every reply has come back
    task automatic pause_sender();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic random_phase(input int count, input logic [KEY_W-1:0] base,
                                input int span, input int zero_pct);
        int                 r;
        logic [OP_W-1:0]    op;
        logic [MONEY_W-1:0] opnd;
        for (int n = 0; n < count; n++) begin
            r = $urandom_range(0, 99);
            if (r < 34)
                op = bkvft_pkg::OP_SET;
            else if (r < 48)
                op = bkvft_pkg::OP_SIGNED_ADD;
            else if (r < 62)
                op = bkvft_pkg::OP_UNSIGNED_ADD;
            else if (r < 74)
                op = bkvft_pkg::OP_MONEY_SET;
            else if (r < 90)
                op = bkvft_pkg::OP_MONEY_ADD;
            else
                op = OP_W'($urandom_range(OP_RESERVED_LO, OP_RESERVED_HI));
            if (op == bkvft_pkg::OP_MONEY_SET || op == bkvft_pkg::OP_MONEY_ADD)
                opnd = money_operand();
            else
                opnd = field_operand(zero_pct);
            send_command(op, pick_key(base, span), opnd);
        end
    endtask

    // Receiver: random backpressure, always ready when calm, one long hold-off on request
    initial begin : receiver
        int hold_left;
        bit hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_left > 0) begin
                out_ready <= 1'b0;
                hold_left--;
            end else if (rx_hold_req && !hold_taken) begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
                out_ready  <= 1'b0;
            end else if (calm) begin
                out_ready <= 1'b1;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= 33);
            end
        end
    end

    // Watchdog
    initial begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge clk);
            cycles++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        int               span;
        int               zero_pct;
        logic [KEY_W-1:0] base;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Field extremes, wrapping adds and delete by zero
        send_command(bkvft_pkg::OP_SET, 16'h0000, 64'h0000_0000_0000_0001);
        send_command(bkvft_pkg::OP_SET, 16'hFFFF, 64'hDEAD_BEEF_FFFF_FFFF);
        send_command(bkvft_pkg::OP_SIGNED_ADD, 16'hFFFF, 64'h0000_0000_0000_0001);
        send_command(bkvft_pkg::OP_UNSIGNED_ADD, 16'h0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(bkvft_pkg::OP_UNSIGNED_ADD, 16'h0007, 64'h0000_0000_0000_0005);
        send_command(bkvft_pkg::OP_SIGNED_ADD, 16'h0007, 64'hFFFF_FFFF_FFFF_FFFB);
        send_command(bkvft_pkg::OP_SET, 16'h0009, 64'hFFFF_FFFF_0000_0000);
        send_command(bkvft_pkg::OP_SET, 16'h000A, 64'h8000_0000_8000_0000);
        send_command(bkvft_pkg::OP_SIGNED_ADD, 16'h000A, 64'h0000_0000_7FFF_FFFF);
        // Money: maximum, overflow clamp, rejected negative set, clamp below zero
        send_command(bkvft_pkg::OP_MONEY_SET, KEY_W'($urandom), 64'h7FFF_FFFF_FFFF_FFFF);
        send_command(bkvft_pkg::OP_MONEY_ADD, KEY_W'($urandom), 64'h0000_0000_0000_0001);
        send_command(bkvft_pkg::OP_MONEY_SET, KEY_W'($urandom), 64'h8000_0000_0000_0000);
        send_command(bkvft_pkg::OP_MONEY_SET, KEY_W'($urandom), 64'h0000_0001_0000_0000);
        send_command(bkvft_pkg::OP_MONEY_ADD, KEY_W'($urandom), 64'hFFFF_FFFE_0000_0000);
        send_command(bkvft_pkg::OP_MONEY_ADD, KEY_W'($urandom), 64'h1234_5678_9ABC_DEF0);
        send_command(bkvft_pkg::OP_SET, bkvft_pkg::MONEY_LOW_KEY, 64'h0);
        send_command(bkvft_pkg::OP_MONEY_ADD, KEY_W'($urandom), 64'hFFFF_FFFF_FFFF_FFFF);
        // Unused operation codes
        send_command(OP_RESERVED_LO, 16'hFFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_command(OP_RESERVED_HI - 3'd1, 16'h0000, rand_word64());
        send_command(OP_RESERVED_HI, KEY_W'($urandom), rand_word64());
        send_command(bkvft_pkg::OP_MONEY_SET, KEY_W'($urandom), 64'h0);
        send_command(bkvft_pkg::OP_SET, 16'h000A, 64'h0);

        // Fill the table while the receiver holds off
        rx_hold_req = 1'b1;
        for (int i = 0; i < 70; i++)
            send_command(bkvft_pkg::OP_SET, KEY_W'(16'h1000 + i),
                         {32'(rand_word64() >> 32), 32'(i + 1)});
        // Full table: money write fails on both keys, then on the high key only
        send_command(bkvft_pkg::OP_MONEY_SET, KEY_W'($urandom), 64'h0000_0005_0000_0007);
        send_command(bkvft_pkg::OP_SET, 16'h1000, 64'h0);
        send_command(bkvft_pkg::OP_MONEY_SET, KEY_W'($urandom), 64'h0000_0005_0000_0007);
        send_command(bkvft_pkg::OP_SIGNED_ADD, 16'h2222, 64'h0000_0000_0000_0003);
        send_command(bkvft_pkg::OP_UNSIGNED_ADD, 16'h1001, 64'h0);
        send_command(bkvft_pkg::OP_MONEY_SET, KEY_W'($urandom), 64'h0);
        pause_sender();

        // Random phases alternating small and large key pools
        for (int phase = 0; phase < 8; phase++) begin
            calm = (phase == 2);
            if (phase == 5)
                pause_sender();
            base     = KEY_W'($urandom);
            span     = (phase % 2 == 0) ? $urandom_range(4, 20) : $urandom_range(60, 120);
            if (phase == 7)
                span = 65536;
            zero_pct = $urandom_range(3, 30);
            random_phase(88, base, span, zero_pct);
        end
        calm = 1'b0;

        // Drain and give the verdict
        pause_sender();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bkvft_pkg.sv
sv/bkvft_alu.sv
sv/bkvft_store.sv
sv/bounded_key_value_field_table_unit.sv
tb/field_table_checker.sv
tb/bounded_key_value_field_table_unit_tb.sv
